@@ sv/arn_pkg.sv @@
// ----------------------------------------------------------------------------
// arn_pkg: shared types and constants of the residual normalizer
// widths of the fixed-point fields, register indexes and controller states
// ----------------------------------------------------------------------------
`default_nettype none

package arn_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 16;  // signed series sample
  localparam int unsigned SQ_W     = 31;  // square of a 16-bit sample, up to 2**30
  localparam int unsigned COEF_W   = 24;  // unsigned Q8.16 weights
  localparam int unsigned EPS_W    = 16;  // unsigned Q0.16 weight
  localparam int unsigned DEN_W    = 57;  // denominator, unsigned Q.16
  localparam int unsigned QUO_W    = 32;  // residual, unsigned Q16.16
  localparam int unsigned LANE_W   = SQ_W + 3;  // sum of up to five lane terms
  localparam int unsigned CNT_W    = 5;         // step counter, covers 24 and 32 steps
  localparam int unsigned NCOEF    = 5;         // coef_0 .. coef_4

  // configuration register indexes
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_COEF_0  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_1  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_2  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEF_3  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COEF_4  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_EPSILON = 3'd5;

  // register reset values
  localparam logic [COEF_W-1:0] COEF_0_RST = 24'h01_0000;  // 1.0 in Q8.16

  // last step of each serial phase
  localparam logic [CNT_W-1:0] MAC_LAST = 5'(COEF_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = 5'(QUO_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,  // waiting for a sample
    ST_MAC,   // bit-serial weighted sum of squares
    ST_SUM,   // add intercept, seed divider
    ST_DIV,   // restoring division, one quotient bit a cycle
    ST_HOLD   // result ready, output register still occupied
  } arn_state_e;

endpackage

`default_nettype wire

@@ sv/arch_residual_normalizer_core.sv @@
// ----------------------------------------------------------------------------
// arch_residual_normalizer_core: standardized squared residual, digit serial
// squares each sample and divides it by an ARCH-style variance estimate
// ----------------------------------------------------------------------------
// One sample per transfer on the slave stream. The sample is squared and, once
// ORDER earlier squares of the current series are held, the block returns
// residual = s / (coef_0 + sum coef_k * s[t-k] + epsilon * s) as unsigned
// Q16.16, saturated to all ones with the flag set on overflow or a zero
// denominator. A transfer with restart set opens a new series and, like every
// warm-up sample, gives no result and leaves the block ready. A sample that
// gives a result occupies the block from its transfer to the next possible
// input transfer: bit-serial multiply-accumulate (one coefficient bit a cycle
// over all lanes at once), an intercept add and restoring division (one
// quotient bit a cycle). The result then enters the output register, or waits
// while that register is occupied; a new sample is taken while it waits in the
// output register. The coefficient and quotient widths set the phase lengths.
// The user must write configuration only while idle; the block does not check.
// ----------------------------------------------------------------------------
`default_nettype none

module arch_residual_normalizer_core
  import arn_pkg::*;
#(
  parameter int unsigned ORDER = 4  // 1 .. 4 earlier squares in the model
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [COEF_W-1:0]    cfg_data_i,
  // sample stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [15:0]          s_axis_tdata,  // [15:0] sample
  input  wire logic                 s_axis_tuser,  // [0] restart
  // result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [31:0]               m_axis_tdata,  // [31:0] residual
  output logic                      m_axis_tuser   // [0] saturated
);

  localparam int unsigned HCNT_W = $clog2(ORDER + 1);
  localparam logic [HCNT_W-1:0] HCNT_FULL = HCNT_W'(ORDER);

  // configuration registers
  logic [COEF_W-1:0] coef_q [NCOEF];
  logic [EPS_W-1:0]  eps_q;

  // series state
  logic [SQ_W-1:0]   hist_q [ORDER];  // entry 0 is one step back
  logic [HCNT_W-1:0] hcnt_q;

  // serial datapath
  logic [COEF_W-1:0] csr_q [ORDER+1];  // coefficient shift lanes, last one epsilon
  logic [SQ_W-1:0]   sq_q;
  logic [DEN_W-1:0]  acc_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q;
  logic [QUO_W-1:0]  quo_q;
  logic              sat_q;
  logic [CNT_W-1:0]  cnt_q;

  // output register
  logic              out_valid_q;
  logic [QUO_W-1:0]  out_res_q;
  logic              out_sat_q;

  arn_state_e state_q, state_d;

  // --------------------------------------------------------------------------
  // input side: magnitude and square of the incoming sample
  // --------------------------------------------------------------------------
  logic                accept;
  logic [SAMPLE_W-1:0] mag;
  logic [2*SAMPLE_W-1:0] sq_full;
  logic [SQ_W-1:0]     sq_in;
  logic [HCNT_W-1:0]   hcnt_eff;
  logic                start;

  assign accept   = s_axis_tvalid && s_axis_tready;
  // two's complement magnitude, the most negative sample maps to 0x8000
  assign mag      = s_axis_tdata[15] ? (~s_axis_tdata + 16'd1) : s_axis_tdata;
  assign sq_full  = mag * mag;
  assign sq_in    = sq_full[SQ_W-1:0];
  // restart empties the history before this sample is looked at
  assign hcnt_eff = s_axis_tuser ? '0 : hcnt_q;
  assign start    = (hcnt_eff == HCNT_FULL);

  // --------------------------------------------------------------------------
  // multiply-accumulate lanes: msb-first, one bit of every weight per cycle
  // --------------------------------------------------------------------------
  logic [LANE_W-1:0] lane_sum;
  logic [DEN_W-1:0]  acc_d;

  always_comb begin
    lane_sum = '0;
    for (int k = 0; k < ORDER; k++) begin
      if (csr_q[k][COEF_W-1]) begin
        lane_sum = lane_sum + LANE_W'(hist_q[k]);
      end
    end
    // epsilon lane weights the current square
    if (csr_q[ORDER][COEF_W-1]) begin
      lane_sum = lane_sum + LANE_W'(sq_q);
    end
    acc_d = (acc_q << 1) + DEN_W'(lane_sum);
  end

  // --------------------------------------------------------------------------
  // restoring divider step: remainder stays below the denominator
  // --------------------------------------------------------------------------
  logic [DEN_W:0]   rem2;
  logic [DEN_W+1:0] diff;
  logic             ge;
  logic [DEN_W-1:0] rem_d;
  logic [QUO_W-1:0] quo_d;
  logic             sat_now;

  assign rem2    = {rem_q, 1'b0};
  assign diff    = {1'b0, rem2} - {2'b00, den_q};
  assign ge      = ~diff[DEN_W+1];
  assign rem_d   = ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
  assign quo_d   = {quo_q[QUO_W-2:0], ge};
  // quotient reaches 2**32 exactly when s >= D, which also covers D == 0
  assign sat_now = ({(DEN_W - SQ_W)'(0), sq_q} >= den_q);

  // --------------------------------------------------------------------------
  // controller
  // --------------------------------------------------------------------------
  logic out_free;
  logic cnt_clr;
  logic mac_en;
  logic sum_en;
  logic div_en;
  logic hist_push;   // push the square held in sq_q
  logic load_now;    // load output from the last divider step
  logic load_held;   // load output from quo_q and sat_q

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    cnt_clr       = 1'b0;
    mac_en        = 1'b0;
    sum_en        = 1'b0;
    div_en        = 1'b0;
    hist_push     = 1'b0;
    load_now      = 1'b0;
    load_held     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cnt_clr       = 1'b1;
        if (s_axis_tvalid && start) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        mac_en = 1'b1;
        if (cnt_q == MAC_LAST) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_en  = 1'b1;
        cnt_clr = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        div_en = 1'b1;
        if (cnt_q == DIV_LAST) begin
          hist_push = 1'b1;
          if (out_free) begin
            load_now = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            state_d  = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_held = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // step counter shared by the two serial phases
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cnt_clr) begin
      cnt_q <= '0;
    end else if (mac_en || div_en) begin
      cnt_q <= cnt_q + 5'd1;
    end
  end

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= COEF_0_RST;
      for (int k = 1; k < NCOEF; k++) begin
        coef_q[k] <= '0;
      end
      eps_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COEF_0:  coef_q[0] <= cfg_data_i;
        REG_COEF_1:  coef_q[1] <= cfg_data_i;
        REG_COEF_2:  coef_q[2] <= cfg_data_i;
        REG_COEF_3:  coef_q[3] <= cfg_data_i;
        REG_COEF_4:  coef_q[4] <= cfg_data_i;
        REG_EPSILON: eps_q     <= cfg_data_i[EPS_W-1:0];
        default: begin
          // indexes beyond the register list are dropped
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // history of squares
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q <= '0;
      for (int k = 0; k < ORDER; k++) begin
        hist_q[k] <= '0;
      end
    end else if (accept && !start) begin
      // warm-up or restart: the square goes straight into the history
      for (int k = ORDER - 1; k > 0; k--) begin
        hist_q[k] <= s_axis_tuser ? '0 : hist_q[k-1];
      end
      hist_q[0] <= sq_in;
      hcnt_q    <= hcnt_eff + HCNT_W'(1);
    end else if (hist_push) begin
      // full history: shift once the divider no longer needs the old entries
      for (int k = ORDER - 1; k > 0; k--) begin
        hist_q[k] <= hist_q[k-1];
      end
      hist_q[0] <= sq_q;
    end
  end

  // --------------------------------------------------------------------------
  // serial datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sq_q  <= sq_in;
      acc_q <= '0;
      for (int k = 0; k < ORDER; k++) begin
        csr_q[k] <= coef_q[k+1];
      end
      csr_q[ORDER] <= {eps_q, (COEF_W - EPS_W)'(0)} >> (COEF_W - EPS_W);
    end else if (mac_en) begin
      acc_q <= acc_d;
      for (int k = 0; k <= ORDER; k++) begin
        csr_q[k] <= csr_q[k] << 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en) begin
      den_q <= acc_q + DEN_W'(coef_q[0]);
      rem_q <= DEN_W'(sq_q);
    end else if (div_en) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      if (cnt_q == '0) begin
        sat_q <= sat_now;
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register: parts the divider from the result stream
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_now || load_held) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_now) begin
      out_res_q <= sat_q ? '1 : quo_d;
      out_sat_q <= sat_q;
    end else if (load_held) begin
      out_res_q <= sat_q ? '1 : quo_q;
      out_sat_q <= sat_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q;
  assign m_axis_tuser  = out_sat_q;

endmodule

`default_nettype wire

@@ sv/arn_checker.sv @@
// ----------------------------------------------------------------------------
// arn_checker: port-level checks of the residual normalizer
// watches both streams of the top level over time
// ----------------------------------------------------------------------------
`default_nettype none

module arn_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [15:0] s_axis_tdata,
  input wire logic        s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  logic s_xfer;

  assign s_xfer = s_axis_tvalid && s_axis_tready;

  // no result shows while reset is held
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // a saturated result always carries the all-ones residual
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 32'hFFFF_FFFF))
    else $error("saturated result without all-ones residual");

  // a result never appears right after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_xfer))
    else $error("result appeared straight after an input transfer");

  // a restart opens a series without a result, so the block stays ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_xfer && s_axis_tuser) |=> s_axis_tready)
    else $error("restart sample started a computation");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind arch_residual_normalizer_core arn_checker u_arn_checker (.*);

`default_nettype wire
